FILE: src/sud_pkg.sv
// ----------------------------------------------------------------------------
// sud_pkg
// Shared widths, defaults and sequencer states for the set union store.
// ----------------------------------------------------------------------------
package sud_pkg;

   localparam int VALUE_W      = 32;
   localparam int POS_W        = 5;
   localparam int CNT_W        = 6;
   localparam int DEF_CAPACITY = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_STATUS,
      ST_DUMP_RD,
      ST_DUMP_WR
   } seq_state_type;

endpackage

FILE: src/sud_store.sv
// ----------------------------------------------------------------------------
// sud_store
// Value store for the set union: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sud_store
   import sud_pkg::*;
#(
   parameter int DEPTH = DEF_CAPACITY,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_addr,
   input  logic [VALUE_W-1:0] wr_data,
   input  logic [IDX_W-1:0]   rd_addr,
   output logic [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/set_union_dedup_store.sv
// ----------------------------------------------------------------------------
// set_union_dedup_store
// Streaming set union: searches each element among the stored distinct
// values, appends it when absent and room remains, reports status and reads out the union.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  req_    | in        | req_valid/req_stall | element_value, start_new,
//          |           |                    | end_of_input
//  rsp_    | out       | rsp_valid/rsp_stall | result_kind, out_value, position,
//          |           |                    | was_new, store_full, union_count,
//          |           |                    | last_of_run
//
//  An item is searched against the N values stored, as one compare per
//  cycle walks the store through its single read port, then its status
//  result is loaded; the next item is taken once the sequencer is idle.
//  Readout of the union reads each entry, then loads it as a result.
//  No new item is taken until all results of the current one are loaded.
//  Reset empties the store; rsp_stall holds the result register and the
//  sequencer waits on it.
// ----------------------------------------------------------------------------
module set_union_dedup_store
   import sud_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [VALUE_W-1:0] req_element_value,
   input  logic                      req_start_new,
   input  logic                      req_end_of_input,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_result_kind,
   output logic signed [VALUE_W-1:0] rsp_out_value,
   output logic [POS_W-1:0]          rsp_position,
   output logic                      rsp_was_new,
   output logic                      rsp_store_full,
   output logic [CNT_W-1:0]          rsp_union_count,
   output logic                      rsp_last_of_run
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   seq_state_type      state_ff, state_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               end_ff, end_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [CNT_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic               new_ff, new_in;
   logic               full_ff, full_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               kind_ff, kind_in;
   logic [VALUE_W-1:0] oval_ff, oval_in;
   logic [POS_W-1:0]   opos_ff, opos_in;
   logic               onew_ff, onew_in;
   logic               ofull_ff, ofull_in;
   logic [CNT_W-1:0]   ocnt_ff, ocnt_in;
   logic               olast_ff, olast_in;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [VALUE_W-1:0] rd_data;
   logic               out_free;
   logic               hit;

   sud_store #(
      .DEPTH (CAPACITY),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (value_ff),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign hit      = cmp_vld_ff && (rd_data == value_ff);
   assign wr_addr  = count_ff[IDX_W-1:0];

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      end_in       = end_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      pos_in       = pos_ff;
      new_in       = new_ff;
      full_in      = full_ff;
      wr_en        = 1'b0;
      req_stall    = (state_ff != ST_IDLE);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      oval_in      = oval_ff;
      opos_in      = opos_ff;
      onew_in      = onew_ff;
      ofull_in     = ofull_ff;
      ocnt_in      = ocnt_ff;
      olast_in     = olast_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               value_in = req_element_value;
               end_in   = req_end_of_input;
               if (req_start_new) begin
                  count_in = '0;
               end
               scan_in  = '0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            priority if (hit) begin
               pos_in   = cmp_idx_ff;
               new_in   = 1'b0;
               full_in  = 1'b0;
               state_in = ST_STATUS;
            end else if (scan_ff < count_ff) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_ff;
               scan_in    = scan_ff + CNT_W'(1);
            end else if (count_ff < CAP_CNT) begin
               wr_en    = 1'b1;
               pos_in   = count_ff;
               new_in   = 1'b1;
               full_in  = 1'b0;
               count_in = count_ff + CNT_W'(1);
               state_in = ST_STATUS;
            end else begin
               pos_in   = '0;
               new_in   = 1'b0;
               full_in  = 1'b1;
               state_in = ST_STATUS;
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = 1'b0;
               oval_in      = value_ff;
               opos_in      = pos_ff[POS_W-1:0];
               onew_in      = new_ff;
               ofull_in     = full_ff;
               ocnt_in      = count_ff;
               olast_in     = !end_ff;
               scan_in      = '0;
               state_in     = (end_ff && count_ff != '0) ? ST_DUMP_RD : ST_IDLE;
            end
         end
         ST_DUMP_RD: begin
            state_in = ST_DUMP_WR;
         end
         ST_DUMP_WR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = 1'b1;
               oval_in      = rd_data;
               opos_in      = scan_ff[POS_W-1:0];
               onew_in      = 1'b0;
               ofull_in     = 1'b0;
               ocnt_in      = count_ff;
               olast_in     = (scan_ff + CNT_W'(1) == count_ff);
               scan_in      = scan_ff + CNT_W'(1);
               state_in     = (scan_ff + CNT_W'(1) == count_ff) ? ST_IDLE : ST_DUMP_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      end_ff     <= end_in;
      scan_ff    <= scan_in;
      cmp_idx_ff <= cmp_idx_in;
      pos_ff     <= pos_in;
      new_ff     <= new_in;
      full_ff    <= full_in;
      kind_ff    <= kind_in;
      oval_ff    <= oval_in;
      opos_ff    <= opos_in;
      onew_ff    <= onew_in;
      ofull_ff   <= ofull_in;
      ocnt_ff    <= ocnt_in;
      olast_ff   <= olast_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_out_value   = oval_ff;
   assign rsp_position    = opos_ff;
   assign rsp_was_new     = onew_ff;
   assign rsp_store_full  = ofull_ff;
   assign rsp_union_count = ocnt_ff;
   assign rsp_last_of_run = olast_ff;

endmodule

FILE: tb/set_union_dedup_store_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_union_dedup_store_tb
// Drives streamed set elements into the union store and checks each result:
// typed table rows against the table, the rest against a behavioral mirror.
// A short table covers value extremes, duplicates, start and end flags,
// then random runs drawn from small pools, with random idle on both channels.
// ----------------------------------------------------------------------------
module set_union_dedup_store_tb;
   import sud_pkg::*;

   localparam int   CAP          = DEF_CAPACITY;
   localparam int   RANDOM_ITEMS = 400;
   localparam int   IDLE_PCT     = 35;
   localparam logic KIND_STATUS  = 1'b0;
   localparam logic KIND_ENTRY   = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   pos;
      logic               was_new;
      logic               store_full;
      logic [CNT_W-1:0]   count;
      logic               last_of_run;
   } union_result_type;

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic               start_new;
      logic               end_of_input;
      logic               typed;
      logic [POS_W-1:0]   pos;
      logic               was_new;
      logic [CNT_W-1:0]   count;
   } dir_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [VALUE_W-1:0] req_element_value = '0;
   logic                      req_start_new = 1'b0;
   logic                      req_end_of_input = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_result_kind;
   logic signed [VALUE_W-1:0] rsp_out_value;
   logic [POS_W-1:0]          rsp_position;
   logic                      rsp_was_new;
   logic                      rsp_store_full;
   logic [CNT_W-1:0]          rsp_union_count;
   logic                      rsp_last_of_run;

   logic [VALUE_W-1:0] union_mirror [CAP];
   int unsigned        mirror_count = 0;
   union_result_type   union_expect_q [$];
   int unsigned        mismatch_count = 0;
   logic               quiet = 1'b0;
   dir_row_type        dir_tab [13];

   set_union_dedup_store dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_element_value (req_element_value),
      .req_start_new     (req_start_new),
      .req_end_of_input  (req_end_of_input),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_out_value     (rsp_out_value),
      .rsp_position      (rsp_position),
      .rsp_was_new       (rsp_was_new),
      .rsp_store_full    (rsp_store_full),
      .rsp_union_count   (rsp_union_count),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   always #1 clock = ~clock;

   // fold one element into the mirror and queue the items it causes
   function automatic void fold_element(logic [VALUE_W-1:0] v, logic s, logic e,
                                        logic typed, union_result_type typed_res);
      union_result_type st;
      union_result_type rd;
      int               hit;
      hit = -1;
      if (s) mirror_count = 0;
      for (int i = 0; i < mirror_count; i++)
         if (hit < 0 && union_mirror[i] == v) hit = i;
      st = '0;
      st.kind = KIND_STATUS;
      st.value = v;
      st.last_of_run = !e;
      if (hit >= 0) begin
         st.pos = POS_W'(hit);
      end else if (mirror_count < CAP) begin
         union_mirror[mirror_count] = v;
         st.pos = POS_W'(mirror_count);
         st.was_new = 1'b1;
         mirror_count++;
      end else begin
         st.store_full = 1'b1;
      end
      st.count = CNT_W'(mirror_count);
      union_expect_q.push_back(typed ? typed_res : st);
      if (e) begin
         for (int i = 0; i < mirror_count; i++) begin
            rd = '0;
            rd.kind = KIND_ENTRY;
            rd.value = union_mirror[i];
            rd.pos = POS_W'(i);
            rd.count = CNT_W'(mirror_count);
            rd.last_of_run = (i == mirror_count - 1);
            union_expect_q.push_back(rd);
         end
      end
   endfunction

   // present one item; returns at the edge that accepts it, valid left high
   task automatic send_item(logic [VALUE_W-1:0] v, logic s, logic e,
                            logic typed, union_result_type typed_res);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_element_value <= v;
      req_start_new     <= s;
      req_end_of_input  <= e;
      do @(posedge clock); while (req_stall);
      fold_element(v, s, e, typed, typed_res);
   endtask

   task automatic drain_results;
      req_valid <= 1'b0;
      while (union_expect_q.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
   end

   always @(posedge clock) begin
      union_result_type got;
      union_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_result_kind, rsp_out_value, rsp_position, rsp_was_new,
                 rsp_store_full, rsp_union_count, rsp_last_of_run};
         if (union_expect_q.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected k=%0d v=%h p=%0d n=%0d f=%0d c=%0d l=%0d",
                     $time, got.kind, got.value, got.pos, got.was_new, got.store_full,
                     got.count, got.last_of_run);
         end else begin
            want = union_expect_q.pop_front();
            if (got !== want) begin
               mismatch_count++;
               $display("%0t: expected k=%0d v=%h p=%0d n=%0d f=%0d c=%0d l=%0d",
                        $time, want.kind, want.value, want.pos, want.was_new,
                        want.store_full, want.count, want.last_of_run);
               $display("%0t: actual   k=%0d v=%h p=%0d n=%0d f=%0d c=%0d l=%0d",
                        $time, got.kind, got.value, got.pos, got.was_new,
                        got.store_full, got.count, got.last_of_run);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      union_result_type   typed_res;
      logic [VALUE_W-1:0] pool [64];
      logic [VALUE_W-1:0] v;
      int unsigned        sent_count;
      int unsigned        run_len;
      int unsigned        pool_n;
      logic               fill_run;
      logic               first_run;

      dir_tab = '{
         '{32'h8000_0000, 1'b1, 1'b0, 1'b1, 5'd0, 1'b1, 6'd1},
         '{32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1, 5'd1, 1'b1, 6'd2},
         '{32'h8000_0000, 1'b0, 1'b0, 1'b1, 5'd0, 1'b0, 6'd2},
         '{32'h0000_0000, 1'b0, 1'b0, 1'b1, 5'd2, 1'b1, 6'd3},
         '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 5'd3, 1'b1, 6'd4},
         '{32'h0000_0000, 1'b0, 1'b0, 1'b1, 5'd2, 1'b0, 6'd4},
         '{32'h5555_5555, 1'b0, 1'b1, 1'b0, 5'd0, 1'b0, 6'd0},
         '{32'hAAAA_AAAA, 1'b1, 1'b1, 1'b0, 5'd0, 1'b0, 6'd0},
         '{32'hAAAA_AAAA, 1'b0, 1'b0, 1'b1, 5'd0, 1'b0, 6'd1},
         '{32'h0000_0001, 1'b1, 1'b0, 1'b1, 5'd0, 1'b1, 6'd1},
         '{32'h8000_0001, 1'b0, 1'b0, 1'b1, 5'd1, 1'b1, 6'd2},
         '{32'h0000_0001, 1'b0, 1'b1, 1'b0, 5'd0, 1'b0, 6'd0},
         '{32'h1234_5678, 1'b0, 1'b1, 1'b0, 5'd0, 1'b0, 6'd0}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         typed_res = '{KIND_STATUS, dir_tab[i].value, dir_tab[i].pos, dir_tab[i].was_new,
                       1'b0, dir_tab[i].count, !dir_tab[i].end_of_input};
         send_item(dir_tab[i].value, dir_tab[i].start_new, dir_tab[i].end_of_input,
                   dir_tab[i].typed, typed_res);
      end
      drain_results();

      sent_count = 0;
      first_run = 1'b1;
      while (sent_count < RANDOM_ITEMS) begin
         quiet <= (sent_count >= 150 && sent_count < 260);
         if (!first_run && $urandom_range(99) < 15) begin
            // stray element with random flags
            send_item($urandom(), $urandom_range(7) == 0, $urandom_range(3) == 0,
                      1'b0, '0);
            sent_count++;
         end else begin
            fill_run = first_run || ($urandom_range(99) < 30);
            run_len  = fill_run ? $urandom_range(36, 46) : $urandom_range(1, 24);
            pool_n   = fill_run ? $urandom_range(34, 40) : $urandom_range(1, 20);
            for (int i = 0; i < pool_n; i++) begin
               case ($urandom_range(3))
                  0: pool[i] = (i == 0) ? $urandom() : pool[0] ^ (32'h1 << $urandom_range(31));
                  1: pool[i] = $urandom_range(7);
                  default: pool[i] = $urandom();
               endcase
            end
            for (int k = 0; k < run_len; k++) begin
               if (!first_run && $urandom_range(5) == 0)
                  v = pool[$urandom_range(pool_n - 1)];
               else
                  v = pool[k % pool_n];
               send_item(v, k == 0, k == run_len - 1, 1'b0, '0);
               sent_count++;
            end
            first_run = 1'b0;
         end
         if ($urandom_range(99) < 10) drain_results();
      end

      quiet <= 1'b0;
      drain_results();
      repeat (120) @(posedge clock);
      if (mismatch_count == 0 && union_expect_q.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
